// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sau_pkg.sv =====
// ----------------------------------------------------------------------------
// sau_pkg
// Constants and sideband type shared by the sigmoid pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

  localparam int DEF_IN_WIDTH  = 16;
  localparam int DEF_OUT_WIDTH = 16;

  // Fraction bits of the internal exp datapath
  localparam int QF = 30;

  localparam int A_W = 32;  // |x| in Q.28, up to 8.0
  localparam int F_W = 28;  // fraction of x*log2(e)
  localparam int K_W = 4;   // integer part of x*log2(e), at most 11
  localparam int R_W = 30;  // reduced argument, below ln 2
  localparam int P_W = 31;  // exp(-r), up to 1.0 in Q.30

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  localparam int TAYLOR_DEGREE = 9;

  typedef struct packed {
    logic           last;
    logic           neg;
    logic [K_W-1:0] k;
  } sau_tag_t;

endpackage

`default_nettype wire

// ===== hdl/sau_exp_term.sv =====
// ----------------------------------------------------------------------------
// sau_exp_term
// One nested Taylor step of exp(-r): p <= 1 - round(r * p / DIV_N), 4 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_exp_term #(
  parameter int DIV_N = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  sau_pkg::sau_tag_t        in_tag,
  input  logic [sau_pkg::R_W-1:0]  in_r,
  input  logic [sau_pkg::P_W-1:0]  in_p,
  output logic                     out_valid,
  output sau_pkg::sau_tag_t        out_tag,
  output logic [sau_pkg::R_W-1:0]  out_r,
  output logic [sau_pkg::P_W-1:0]  out_p
);
  import sau_pkg::*;

  localparam int X_W = R_W + P_W;
  localparam int Z_W = X_W - QF;
  localparam int M_W = Z_W + 32;
  localparam logic [X_W-1:0] HALF_DIV = X_W'(DIV_N) << (QF - 1);
  localparam logic [31:0]    RECIP    = 32'(64'hFFFF_FFFF / DIV_N);

  logic               va_r, vb_r, vc_r, vd_r;
  sau_tag_t           ta_r, tb_r, tc_r, td_r;
  logic [R_W-1:0]     ra_r, rb_r, rc_r, rd_r;
  logic [X_W-1:0]     x_r;
  logic [X_W-1:0]     x_sum;
  logic [Z_W-1:0]     z_r, zc_r;
  logic [M_W-1:0]     m_r;
  logic [Z_W-1:0]     q0, rem, term;
  logic [P_W-1:0]     p_r, p_nxt;

  assign x_sum = x_r + HALF_DIV;

  // Quotient estimate is low by at most one; fix it from the remainder
  always_comb begin
    q0    = m_r[M_W-1:32];
    rem   = zc_r - q0 * Z_W'(DIV_N);
    term  = q0 + Z_W'(rem >= Z_W'(DIV_N));
    p_nxt = (term >= Z_W'(ONE_Q30)) ? '0 : P_W'(Z_W'(ONE_Q30) - term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r <= in_tag;
      ra_r <= in_r;
      x_r  <= X_W'(in_r) * X_W'(in_p);
      tb_r <= ta_r;
      rb_r <= ra_r;
      z_r  <= x_sum[X_W-1:QF];
      tc_r <= tb_r;
      rc_r <= rb_r;
      zc_r <= z_r;
      m_r  <= M_W'(z_r) * M_W'(RECIP);
      td_r <= tc_r;
      rd_r <= rc_r;
      p_r  <= p_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_tag   = td_r;
  assign out_r     = rd_r;
  assign out_p     = p_r;

endmodule

`default_nettype wire

// ===== hdl/sau_div_pipe.sv =====
// ----------------------------------------------------------------------------
// sau_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_div_pipe #(
  parameter int OUT_WIDTH = sau_pkg::DEF_OUT_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  sau_pkg::sau_tag_t                     in_tag,
  input  logic [sau_pkg::QF+OUT_WIDTH:0]        in_num,
  input  logic [31:0]                           in_den,
  output logic                                  out_valid,
  output sau_pkg::sau_tag_t                     out_tag,
  output logic [OUT_WIDTH:0]                    out_q
);
  import sau_pkg::*;

  localparam int STEPS = OUT_WIDTH + 1;
  localparam int NUM_W = QF + OUT_WIDTH + 1;
  localparam int REM_W = 32;

  logic [STEPS-1:0] v_r;
  sau_tag_t         tag_r   [STEPS];
  logic [REM_W-1:0] rem_r   [STEPS];
  logic [REM_W-1:0] den_r   [STEPS];
  logic [STEPS-1:0] sh_r    [STEPS];

  sau_tag_t         tag_in  [STEPS];
  logic [REM_W-1:0] rem_in  [STEPS];
  logic [REM_W-1:0] den_in  [STEPS];
  logic [STEPS-1:0] sh_in   [STEPS];
  logic [REM_W-1:0] trial   [STEPS];
  logic [REM_W-1:0] rem_nxt [STEPS];
  logic [STEPS-1:0] sh_nxt  [STEPS];
  logic [STEPS-1:0] ge;

  // Upper numerator bits seed the remainder; lower bits shift in one a stage
  assign tag_in[0] = in_tag;
  assign rem_in[0] = REM_W'(in_num[NUM_W-1:STEPS]);
  assign den_in[0] = in_den;
  assign sh_in[0]  = in_num[STEPS-1:0];

  for (genvar i = 1; i < STEPS; i++) begin : g_link
    assign tag_in[i] = tag_r[i-1];
    assign rem_in[i] = rem_r[i-1];
    assign den_in[i] = den_r[i-1];
    assign sh_in[i]  = sh_r[i-1];
  end

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      trial[i]   = {rem_in[i][REM_W-2:0], sh_in[i][STEPS-1]};
      ge[i]      = trial[i] >= den_in[i];
      rem_nxt[i] = ge[i] ? trial[i] - den_in[i] : trial[i];
      sh_nxt[i]  = {sh_in[i][STEPS-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STEPS; i++) begin
        tag_r[i] <= tag_in[i];
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_in[i];
        sh_r[i]  <= sh_nxt[i];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_tag   = tag_r[STEPS-1];
  assign out_q     = sh_r[STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/sigmoid_activation_unit.sv =====
// ----------------------------------------------------------------------------
// sigmoid_activation_unit
// Streaming logistic sigmoid 1/(1+exp(-x)): signed Q4.12 in, Q0.16 out.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                                   Direction  Moves
//   in       in_valid, in_stall, in_sample_in,       sink       one sample
//            in_last_in
//   out      out_valid, out_stall, out_sigmoid_out,  source     one sigmoid
//            out_last_out
//
// Throughput: one request per cycle, every cycle, as long as results are taken.
// Pipeline: magnitude and range reduction, the nine 4-stage Taylor steps,
//   scaling by 2^-k and the one-bit-per-stage divider.
// Reset: synchronous, active low; clears valid bits only.
// Stalls: a result refused at the output drops into a skid register while the
//   pipe keeps moving for that cycle; a full skid register freezes the pipe and
//   raises in_stall, so nothing is lost or repeated.
//
// Datapath: |x|*log2(e) splits into integer k and fraction f; r = f*ln2; a
// nested degree-9 Taylor series gives exp(-r); a rounded shift by k gives
// e = exp(-|x|); the divider forms 1/(1+e) or e/(1+e).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sigmoid_activation_unit #(
  parameter int IN_WIDTH  = sau_pkg::DEF_IN_WIDTH,
  parameter int OUT_WIDTH = sau_pkg::DEF_OUT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [IN_WIDTH-1:0]  in_sample_in,
  input  logic                        in_last_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [OUT_WIDTH-1:0]        out_sigmoid_out,
  output logic                        out_last_out
);
  import sau_pkg::*;

  localparam int A_SHIFT = A_W - IN_WIDTH;
  localparam int PA_W    = A_W + 31;   // |x| * log2(e)
  localparam int PF_W    = F_W + R_W;  // f * ln2
  localparam int NUM_W   = QF + OUT_WIDTH + 1;
  localparam logic [PA_W-1:0] T_RND = PA_W'(1) << (QF - 1);
  localparam logic [PF_W-1:0] R_RND = PF_W'(1) << (F_W - 1);

  // Global advance: the pipe moves unless the skid register is occupied
  logic en;

  // ---- stage 1: magnitude, aligned to Q.28
  logic                s1_valid_r, s1_neg_r, s1_last_r;
  logic [A_W-1:0]      s1_a_r;
  logic [IN_WIDTH-1:0] smp_u, mag;

  // ---- stage 2: |x| * log2(e)
  logic                s2_valid_r, s2_neg_r, s2_last_r;
  logic [PA_W-1:0]     s2_prod_r;

  // ---- stage 3: round, split into k and f
  logic                s3_valid_r;
  sau_tag_t            s3_tag_r;
  logic [F_W-1:0]      s3_f_r;
  logic [PA_W-1:0]     t_sum;
  logic [A_W-1:0]      t_val;

  // ---- stage 4: f * ln2
  logic                s4_valid_r;
  sau_tag_t            s4_tag_r;
  logic [PF_W-1:0]     s4_prod_r;

  // ---- stage 5: reduced argument r
  logic                s5_valid_r;
  sau_tag_t            s5_tag_r;
  logic [R_W-1:0]      s5_red_r;
  logic [PF_W-1:0]     r_sum;

  // ---- Taylor chain
  logic                tc_valid [TAYLOR_DEGREE+1];
  sau_tag_t            tc_tag   [TAYLOR_DEGREE+1];
  logic [R_W-1:0]      tc_r     [TAYLOR_DEGREE+1];
  logic [P_W-1:0]      tc_p     [TAYLOR_DEGREE+1];

  // ---- scale by 2^-k, form 1 + e
  logic                se_valid_r;
  sau_tag_t            se_tag_r;
  logic [P_W-1:0]      se_e_r;
  logic [31:0]         se_d_r;
  logic [K_W-1:0]      fin_k;
  logic [P_W-1:0]      e_rnd, e_sum, e_nxt;

  // ---- divider operands
  logic                sn_valid_r;
  sau_tag_t            sn_tag_r;
  logic [NUM_W-1:0]    sn_num_r, num_nxt;
  logic [31:0]         sn_den_r;

  // ---- divider result
  logic                dv_valid;
  sau_tag_t            dv_tag;
  logic [OUT_WIDTH:0]  dv_q;
  logic [OUT_WIDTH-1:0] dv_sat;

  // ---- output register and skid
  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [OUT_WIDTH-1:0] out_sig_r, skid_sig_r;
  logic                 out_last_r, skid_last_r;
  logic                 take, load_out, load_skid;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Two's complement magnitude; the most negative code maps to exactly 8.0
  assign smp_u = in_sample_in;
  assign mag   = smp_u[IN_WIDTH-1] ? (~smp_u + 1'b1) : smp_u;

  assign t_sum = s2_prod_r + T_RND;
  assign t_val = t_sum[QF+A_W-1:QF];
  assign r_sum = s4_prod_r + R_RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      se_valid_r <= 1'b0;
      sn_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      se_valid_r <= tc_valid[TAYLOR_DEGREE];
      sn_valid_r <= se_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r  <= smp_u[IN_WIDTH-1];
      s1_last_r <= in_last_in;
      s1_a_r    <= A_W'(mag) << A_SHIFT;

      s2_neg_r  <= s1_neg_r;
      s2_last_r <= s1_last_r;
      s2_prod_r <= PA_W'(s1_a_r) * PA_W'(LOG2E_Q30);

      s3_tag_r.last <= s2_last_r;
      s3_tag_r.neg  <= s2_neg_r;
      s3_tag_r.k    <= t_val[A_W-1:F_W];
      s3_f_r        <= t_val[F_W-1:0];

      s4_tag_r  <= s3_tag_r;
      s4_prod_r <= PF_W'(s3_f_r) * PF_W'(LN2_Q30);

      s5_tag_r  <= s4_tag_r;
      s5_red_r  <= r_sum[PF_W-1:F_W];
    end
  end

  // Nested Taylor series: the highest-order term runs first
  assign tc_valid[0] = s5_valid_r;
  assign tc_tag[0]   = s5_tag_r;
  assign tc_r[0]     = s5_red_r;
  assign tc_p[0]     = ONE_Q30;

  for (genvar i = 0; i < TAYLOR_DEGREE; i++) begin : g_term
    sau_exp_term #(
      .DIV_N (TAYLOR_DEGREE - i)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (tc_valid[i]),
      .in_tag    (tc_tag[i]),
      .in_r      (tc_r[i]),
      .in_p      (tc_p[i]),
      .out_valid (tc_valid[i+1]),
      .out_tag   (tc_tag[i+1]),
      .out_r     (tc_r[i+1]),
      .out_p     (tc_p[i+1])
    );
  end

  // e = round(p / 2^k); k is at most 11 here
  always_comb begin
    fin_k = tc_tag[TAYLOR_DEGREE].k;
    e_rnd = (fin_k == '0) ? '0 : (P_W'(1) << (fin_k - 1'b1));
    e_sum = tc_p[TAYLOR_DEGREE] + e_rnd;
    e_nxt = e_sum >> fin_k;
  end

  // Negative inputs divide e, positive ones divide 1; both round to nearest
  always_comb begin
    if (se_tag_r.neg) begin
      num_nxt = (NUM_W'(se_e_r) << OUT_WIDTH) + NUM_W'(se_d_r >> 1);
    end else begin
      num_nxt = (NUM_W'(1) << (QF + OUT_WIDTH)) + NUM_W'(se_d_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_tag_r <= tc_tag[TAYLOR_DEGREE];
      se_e_r   <= e_nxt;
      se_d_r   <= 32'(ONE_Q30) + 32'(e_nxt);
      sn_tag_r <= se_tag_r;
      sn_num_r <= num_nxt;
      sn_den_r <= se_d_r;
    end
  end

  sau_div_pipe #(
    .OUT_WIDTH (OUT_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sn_valid_r),
    .in_tag    (sn_tag_r),
    .in_num    (sn_num_r),
    .in_den    (sn_den_r),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .out_q     (dv_q)
  );

  // Quotient never exceeds 2^OUT_WIDTH; clamp that one case to full scale
  assign dv_sat = dv_q[OUT_WIDTH] ? '1 : dv_q[OUT_WIDTH-1:0];

  // Output register with skid: park a refused result instead of stalling at once
  always_comb begin
    take           = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    priority if (skid_valid_r) begin
      if (take) begin
        load_out       = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (dv_valid) begin
      if (!out_valid_r || take) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end else begin
      // hold: nothing arrives and nothing leaves
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sig_r  <= skid_valid_r ? skid_sig_r : dv_sat;
      out_last_r <= skid_valid_r ? skid_last_r : dv_tag.last;
    end
    if (load_skid) begin
      skid_sig_r  <= dv_sat;
      skid_last_r <= dv_tag.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sigmoid_out = out_sig_r;
  assign out_last_out    = out_last_r;

  // ---- checks
  `ASSERT_NEXT(a_skid_fill, en && dv_valid && out_valid_r && out_stall, skid_valid_r, "refused result not parked in skid")
  `ASSERT_IMPLIES(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds a result while output is empty")
  `ASSERT_NEXT(a_skid_hold, skid_valid_r && out_stall, skid_valid_r && $stable(skid_sig_r), "parked result lost under stall")
  `ASSERT_NEXT(a_pipe_frozen, !en, dv_valid == $past(dv_valid) && dv_q == $past(dv_q), "pipe moved while frozen")

endmodule

`default_nettype wire
